@@ src/pfe_pkg.sv @@
// Shared types, constants and helper functions of the Playfair digraph encryptor.
`default_nettype none

package pfe_pkg;

    localparam int SIDE        = 5;
    localparam int CELLS       = SIDE * SIDE;
    localparam int NUM_LETTERS = 26;

    localparam logic [4:0] LETTER_J   = 5'd9;
    localparam logic [4:0] CODE_SPACE = 5'd26;
    localparam logic [4:0] LAST_CODE  = 5'd25;
    localparam logic [4:0] FILLER_RST = 5'd23;

    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_KEY     = 2'd1;
    localparam logic [1:0] REQ_FINISH  = 2'd2;
    localparam logic [1:0] REQ_MESSAGE = 2'd3;

    typedef enum logic {
        CMD_PLACE,
        CMD_PAIR
    } cmd_kind_t;

    // A place command carries the letter in a and the cell index in b.
    // A pair command carries the two plain letters of one digraph.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [4:0] a;
        logic [4:0] b;
        logic       last;
    } cmd_t;

    // True for a code that sits in a completed square.
    function automatic logic in_alphabet(input logic [4:0] code);
        in_alphabet = (code <= LAST_CODE) && (code != LETTER_J);
    endfunction

    function automatic logic [2:0] pos_row(input logic [4:0] pos);
        logic [2:0] row;
        row = 3'd0;
        if (pos >= 5'd20) begin
            row = 3'd4;
        end else if (pos >= 5'd15) begin
            row = 3'd3;
        end else if (pos >= 5'd10) begin
            row = 3'd2;
        end else if (pos >= 5'd5) begin
            row = 3'd1;
        end
        pos_row = row;
    endfunction

    function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
        cell_addr = 5'({row, 2'b00}) + 5'(row) + 5'(col);
    endfunction

    function automatic logic [2:0] pos_col(input logic [4:0] pos);
        logic [4:0] base;
        base    = cell_addr(pos_row(pos), 3'd0);
        pos_col = 3'(pos - base);
    endfunction

    function automatic logic [2:0] next_index(input logic [2:0] idx);
        next_index = (idx == 3'(SIDE - 1)) ? 3'd0 : 3'(idx + 3'd1);
    endfunction

endpackage

`default_nettype wire

@@ src/pfe_front.sv @@
// Front end: accepts items, keeps key and digraph bookkeeping, issues commands.
`default_nettype none

module pfe_front
    import pfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [4:0] filler,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] req_type,
    input  wire logic [4:0] letter,
    input  wire logic       end_of_message,
    output logic            push_valid,
    output cmd_t            push_cmd,
    input  wire logic       push_ready
);

    typedef enum logic {
        F_IDLE,
        F_WALK
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [NUM_LETTERS-1:0] used_reg, used_next;
    logic [4:0] fill_reg, fill_next;
    logic       ready_reg, ready_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [4:0] pend_letter_reg, pend_letter_next;
    logic [4:0] walk_reg, walk_next;
    logic       slot_a_valid_reg, slot_a_valid_next;
    logic       slot_b_valid_reg, slot_b_valid_next;
    cmd_t       slot_a_reg, slot_a_next;
    cmd_t       slot_b_reg, slot_b_next;

    logic       accept;
    logic       walk_cand;
    logic       d1_hit, d1_ok, d2_ok;
    logic [4:0] d1_b;
    logic       mid_valid;
    logic [4:0] mid_letter;
    cmd_t       d1_cmd, d2_cmd, walk_cmd;

    assign in_ready  = (state_reg == F_IDLE) && !slot_a_valid_reg && !slot_b_valid_reg;
    assign accept    = in_valid && in_ready;
    assign walk_cand = (walk_reg != LETTER_J) && !used_reg[walk_reg];

    always_comb
    begin
        walk_cmd.kind = CMD_PLACE;
        walk_cmd.a    = walk_reg;
        walk_cmd.b    = fill_reg;
        walk_cmd.last = 1'b0;
        push_valid    = slot_a_valid_reg || ((state_reg == F_WALK) && walk_cand);
        push_cmd      = slot_a_valid_reg ? slot_a_reg : walk_cmd;
    end

    // Digraph formation for a message letter.
    always_comb
    begin
        d1_hit     = 1'b0;
        d1_b       = letter;
        mid_valid  = pend_valid_reg;
        mid_letter = pend_letter_reg;
        if (letter != CODE_SPACE) begin
            if (!pend_valid_reg) begin
                mid_valid  = 1'b1;
                mid_letter = letter;
            end else if (pend_letter_reg == letter) begin
                d1_hit = 1'b1;
                d1_b   = filler;
            end else begin
                d1_hit     = 1'b1;
                mid_valid  = 1'b0;
                mid_letter = 5'd0;
            end
        end
        d1_ok = d1_hit && in_alphabet(pend_letter_reg) && in_alphabet(d1_b);
        d2_ok = end_of_message && mid_valid && in_alphabet(mid_letter) && in_alphabet(filler);

        d1_cmd.kind = CMD_PAIR;
        d1_cmd.a    = pend_letter_reg;
        d1_cmd.b    = d1_b;
        d1_cmd.last = !d2_ok;
        d2_cmd.kind = CMD_PAIR;
        d2_cmd.a    = mid_letter;
        d2_cmd.b    = filler;
        d2_cmd.last = 1'b1;
    end

    always_comb
    begin
        state_next        = state_reg;
        used_next         = used_reg;
        fill_next         = fill_reg;
        ready_next        = ready_reg;
        pend_valid_next   = pend_valid_reg;
        pend_letter_next  = pend_letter_reg;
        walk_next         = walk_reg;
        slot_a_valid_next = slot_a_valid_reg;
        slot_b_valid_next = slot_b_valid_reg;
        slot_a_next       = slot_a_reg;
        slot_b_next       = slot_b_reg;

        // Drain the command slots in order.
        if (slot_a_valid_reg && push_ready) begin
            slot_a_next       = slot_b_reg;
            slot_a_valid_next = slot_b_valid_reg;
            slot_b_valid_next = 1'b0;
        end

        // Completion walk over the alphabet, one letter a cycle while the queue takes each placed letter.
        if (state_reg == F_WALK) begin
            if (!walk_cand || push_ready) begin
                if (walk_cand) begin
                    used_next[walk_reg] = 1'b1;
                    fill_next           = fill_reg + 5'd1;
                end
                if (walk_reg == LAST_CODE) begin
                    state_next = F_IDLE;
                    ready_next = 1'b1;
                end else begin
                    walk_next = walk_reg + 5'd1;
                end
            end
        end

        if (accept) begin
            case (req_type)
                REQ_CLEAR:
                begin
                    used_next        = '0;
                    fill_next        = 5'd0;
                    ready_next       = 1'b0;
                    pend_valid_next  = 1'b0;
                    pend_letter_next = 5'd0;
                end
                REQ_KEY:
                begin
                    if (!ready_reg && in_alphabet(letter) && !used_reg[letter]) begin
                        slot_a_next.kind    = CMD_PLACE;
                        slot_a_next.a       = letter;
                        slot_a_next.b       = fill_reg;
                        slot_a_next.last    = 1'b0;
                        slot_a_valid_next   = 1'b1;
                        used_next[letter]   = 1'b1;
                        fill_next           = fill_reg + 5'd1;
                    end
                end
                REQ_FINISH:
                begin
                    if (!ready_reg) begin
                        state_next = F_WALK;
                        walk_next  = 5'd0;
                    end
                end
                REQ_MESSAGE:
                begin
                    if (ready_reg) begin
                        if (d2_ok) begin
                            pend_valid_next  = 1'b0;
                            pend_letter_next = 5'd0;
                        end else if (end_of_message && mid_valid) begin
                            pend_valid_next  = 1'b0;
                            pend_letter_next = 5'd0;
                        end else begin
                            pend_valid_next  = mid_valid;
                            pend_letter_next = mid_letter;
                        end
                        if (d1_ok) begin
                            slot_a_next       = d1_cmd;
                            slot_a_valid_next = 1'b1;
                            slot_b_next       = d2_cmd;
                            slot_b_valid_next = d2_ok;
                        end else begin
                            slot_a_next       = d2_cmd;
                            slot_a_valid_next = d2_ok;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= F_IDLE;
            used_reg         <= '0;
            fill_reg         <= 5'd0;
            ready_reg        <= 1'b0;
            pend_valid_reg   <= 1'b0;
            pend_letter_reg  <= 5'd0;
            walk_reg         <= 5'd0;
            slot_a_valid_reg <= 1'b0;
            slot_b_valid_reg <= 1'b0;
        end else begin
            state_reg        <= state_next;
            used_reg         <= used_next;
            fill_reg         <= fill_next;
            ready_reg        <= ready_next;
            pend_valid_reg   <= pend_valid_next;
            pend_letter_reg  <= pend_letter_next;
            walk_reg         <= walk_next;
            slot_a_valid_reg <= slot_a_valid_next;
            slot_b_valid_reg <= slot_b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_a_reg <= slot_a_next;
        slot_b_reg <= slot_b_next;
    end

endmodule

`default_nettype wire

@@ src/pfe_queue.sv @@
// Command queue between the front end and the back end.
`default_nettype none

module pfe_queue
    import pfe_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    input  cmd_t      push_cmd,
    output logic      push_ready,
    output logic      pop_valid,
    output cmd_t      pop_cmd,
    input  wire logic pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ src/pfe_back.sv @@
// Back end: owns the key square memories and encrypts digraphs.
`default_nettype none

module pfe_back
    import pfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pop_valid,
    input  cmd_t            pop_cmd,
    output logic            pop_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [4:0]      cipher_letter,
    output logic            last_of_run
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOOKUP,
        B_FETCH,
        B_SEND_X,
        B_SEND_Y
    } back_state_t;

    logic [4:0] square_cells    [CELLS];
    logic [4:0] letter_position [NUM_LETTERS];

    back_state_t state_reg;
    logic        out_valid_reg;
    logic [4:0]  out_letter_reg;
    logic        out_last_reg;
    logic        last_reg;
    logic [4:0]  y_reg;
    logic [4:0]  pos_a_reg, pos_b_reg;
    logic [4:0]  cell_x_reg, cell_y_reg;

    logic        take;
    logic [2:0]  ra, ca, rb, cb;
    logic [4:0]  addr_x, addr_y;

    assign pop_ready     = (state_reg == B_IDLE);
    assign take          = pop_valid && pop_ready;
    assign out_valid     = out_valid_reg;
    assign cipher_letter = out_letter_reg;
    assign last_of_run   = out_last_reg;

    // Playfair rules on the two looked-up positions.
    always_comb
    begin
        ra = pos_row(pos_a_reg);
        ca = pos_col(pos_a_reg);
        rb = pos_row(pos_b_reg);
        cb = pos_col(pos_b_reg);
        if (ra == rb) begin
            addr_x = cell_addr(ra, next_index(ca));
            addr_y = cell_addr(rb, next_index(cb));
        end else if (ca == cb) begin
            addr_x = cell_addr(next_index(ra), ca);
            addr_y = cell_addr(next_index(rb), cb);
        end else begin
            addr_x = cell_addr(ra, cb);
            addr_y = cell_addr(rb, ca);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && (pop_cmd.kind == CMD_PLACE)) begin
            square_cells[pop_cmd.b]    <= pop_cmd.a;
            letter_position[pop_cmd.a] <= pop_cmd.b;
        end
        if (take && (pop_cmd.kind == CMD_PAIR)) begin
            pos_a_reg <= letter_position[pop_cmd.a];
            pos_b_reg <= letter_position[pop_cmd.b];
            last_reg  <= pop_cmd.last;
        end
        if (state_reg == B_LOOKUP) begin
            cell_x_reg <= square_cells[addr_x];
            cell_y_reg <= square_cells[addr_y];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= B_IDLE;
            out_valid_reg  <= 1'b0;
            out_letter_reg <= 5'd0;
            out_last_reg   <= 1'b0;
            y_reg          <= 5'd0;
        end else begin
            case (state_reg)
                B_IDLE:
                begin
                    if (take && (pop_cmd.kind == CMD_PAIR)) begin
                        state_reg <= B_LOOKUP;
                    end
                end
                B_LOOKUP:
                begin
                    state_reg <= B_FETCH;
                end
                B_FETCH:
                begin
                    out_valid_reg  <= 1'b1;
                    out_letter_reg <= cell_x_reg;
                    out_last_reg   <= 1'b0;
                    y_reg          <= cell_y_reg;
                    state_reg      <= B_SEND_X;
                end
                B_SEND_X:
                begin
                    if (out_ready) begin
                        out_letter_reg <= y_reg;
                        out_last_reg   <= last_reg;
                        state_reg      <= B_SEND_Y;
                    end
                end
                B_SEND_Y:
                begin
                    if (out_ready) begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/playfair_digraph_encryptor.sv @@
// Top level of the Playfair digraph encryptor: filler register and the three parts.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------------
//   input    | in_valid / in_ready | req_type[1:0], letter[4:0], end_of_message
//   output   | out_valid/out_ready | cipher_letter[4:0], last_of_run
//   config   | cfg_we              | cfg_wdata[4:0] (filler letter)
//
// The front end takes an item and then issues its commands one by one into the queue; it takes
// no new item until they are all issued. Finishing the key holds the input while the alphabet
// is walked. The back end takes a digraph through position lookup, cell lookup, output load and
// two output beats, and takes no new command until the second beat is sent; a square write is
// done as the command is taken. Reset clears all control state and sets the filler to x; the
// square memories are not cleared. A stalled output only holds the back end: the command queue
// lets the front end keep taking items until the queue fills.
`default_nettype none

module playfair_digraph_encryptor
    import pfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] req_type,
    input  wire logic [4:0] letter,
    input  wire logic       end_of_message,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [4:0]      cipher_letter,
    output logic            last_of_run
);

    logic [4:0] filler_reg;

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic pop_valid, pop_ready;
    cmd_t pop_cmd;

    // The filler letter is to be written only while the block is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filler_reg <= FILLER_RST;
        end
        else if (cfg_we)
        begin
            filler_reg <= cfg_wdata;
        end
    end

    // Front end: key bookkeeping, digraph pairing and command issue.
    pfe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .filler         (filler_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .letter         (letter),
        .end_of_message (end_of_message),
        .push_valid     (push_valid),
        .push_cmd       (push_cmd),
        .push_ready     (push_ready)
    );

    // Commands keep their order, so square writes and digraph reads never cross.
    pfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    // Back end: square memories and digraph encryption.
    pfe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_cmd       (pop_cmd),
        .pop_ready     (pop_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cipher_letter (cipher_letter),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire
